[rtl/core/hqp_pkg.sv]
package hqp_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CFG_W     = 11;
    localparam int EFF_W     = (SLOT_W + 1 > CFG_W) ? SLOT_W + 1 : CFG_W;
    localparam int SUM_W     = EFF_W + 1;
    localparam int KEY_W     = 31;
    localparam int STAT_W    = 2;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1021);

    // remainder unit: DIV_BITS dividend bits per cycle
    localparam int DIV_BITS  = 4;
    localparam int KEY_PAD_W = ((KEY_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_STEPS = KEY_PAD_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int S_TDATA_W = ((KEY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SLOT_W + 7) / 8) * 8;

    typedef enum logic [STAT_W-1:0] {
        ST_PRESENT = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic div_step;
        logic probe_rd;
        logic probe_cmp;
        logic out_load;
    } hqp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic found;
        logic last_probe;
    } hqp_sts_t;

endpackage

[rtl/core/hqp_ctrl.sv]
module hqp_ctrl
    import hqp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     m_ready,
    output logic     m_valid,
    input  hqp_sts_t sts,
    output hqp_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_RD    = 6'b001000,
        S_CMP   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                cmd.probe_rd = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP: begin
                cmd.probe_cmp = 1'b1;
                if (sts.found || sts.last_probe) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_RD;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg == S_DIV)
        else $error("accepted word did not start remainder");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result shown without finished search");

endmodule

[rtl/core/hqp_dpath.sv]
module hqp_dpath
    import hqp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_mode,
    input  logic [KEY_W-1:0]  in_key,
    input  hqp_cmd_t          cmd,
    output hqp_sts_t          sts,
    output logic [SLOT_W-1:0] out_slot,
    output status_t           out_status
);

    logic [CFG_W-1:0]     size_cfg_reg;
    logic [EFF_W-1:0]     size_eff;
    logic [SLOT_W-1:0]    size_m1;

    logic                 mode_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [KEY_PAD_W-1:0] dvd_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SLOT_W-1:0]    rem_reg, rem_next;

    logic [SLOT_W-1:0]    n_reg, sq_reg, km_reg;
    logic [SLOT_W-1:0]    pos_reg, pos_w;
    logic [SLOT_W-1:0]    clr_reg;

    logic [KEY_W:0]       mem [MAX_SLOTS];
    logic [KEY_W:0]       rd_q;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;
    logic [KEY_W:0]       mem_wdata;

    logic                 slot_empty, slot_hit;
    logic [SLOT_W-1:0]    n_inc, kk, sq_half, sq_full;

    logic [SLOT_W-1:0]    res_slot_reg;
    status_t              res_status_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    status_t              m_status_reg;

    function automatic logic [SLOT_W-1:0] mod_add(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b,
                                                  input logic [EFF_W-1:0]  m);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(m)) begin
            s = s - SUM_W'(m);
        end
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] mod_sub(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b,
                                                  input logic [EFF_W-1:0]  m);
        logic [SUM_W-1:0] s;
        if (a >= b) begin
            s = SUM_W'(a) - SUM_W'(b);
        end else begin
            s = SUM_W'(a) + SUM_W'(m) - SUM_W'(b);
        end
        return s[SLOT_W-1:0];
    endfunction

    always_comb begin
        size_eff = EFF_W'(size_cfg_reg);
        if (size_eff > EFF_W'(MAX_SLOTS)) begin
            size_eff = EFF_W'(MAX_SLOTS);
        end else if (size_eff == '0) begin
            size_eff = EFF_W'(1);
        end
    end

    assign size_m1 = SLOT_W'(size_eff - EFF_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cfg_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            size_cfg_reg <= cfg_data;
        end
    end

    // restoring remainder, DIV_BITS bits per cycle
    always_comb begin
        logic [EFF_W-1:0]  t;
        logic [SLOT_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = EFF_W'({r, dvd_reg[KEY_PAD_W-1-i]});
            if (t >= size_eff) begin
                t = t - size_eff;
            end
            r = t[SLOT_W-1:0];
        end
        rem_next = r;
    end

    // rem_reg holds the home slot once the remainder is done
    always_comb begin
        if (n_reg == '0) begin
            pos_w = rem_reg;
        end else if (n_reg[0]) begin
            pos_w = mod_add(rem_reg, sq_reg, size_eff);
        end else begin
            pos_w = mod_sub(rem_reg, sq_reg, size_eff);
        end
    end

    // k*k mod size kept incrementally: k*k = (k-1)^2 + (k-1) + k
    assign n_inc   = n_reg + SLOT_W'(1);
    assign kk      = mod_add(km_reg, SLOT_W'(1), size_eff);
    assign sq_half = mod_add(sq_reg, km_reg, size_eff);
    assign sq_full = mod_add(sq_half, kk, size_eff);

    assign slot_empty = !rd_q[KEY_W];
    assign slot_hit   = rd_q[KEY_W] && (rd_q[KEY_W-1:0] == key_reg);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg    <= in_mode;
            key_reg     <= in_key;
            dvd_reg     <= KEY_PAD_W'(in_key);
            div_cnt_reg <= '0;
            rem_reg     <= '0;
            n_reg       <= '0;
            sq_reg      <= '0;
            km_reg      <= '0;
        end
        if (cmd.div_step) begin
            dvd_reg     <= dvd_reg << DIV_BITS;
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            rem_reg     <= rem_next;
        end
        if (cmd.probe_rd) begin
            pos_reg <= pos_w;
        end
        if (cmd.probe_cmp) begin
            if (slot_empty || slot_hit) begin
                res_slot_reg   <= pos_reg;
                res_status_reg <= slot_empty ? ST_EMPTY : ST_PRESENT;
            end else if (n_reg == size_m1) begin
                res_slot_reg   <= '0;
                res_status_reg <= ST_FULL;
            end else begin
                n_reg <= n_inc;
                if (n_inc[0]) begin
                    sq_reg <= sq_full;
                    km_reg <= kk;
                end
            end
        end
        if (cmd.out_load) begin
            m_slot_reg   <= res_slot_reg;
            m_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + SLOT_W'(1);
        end
    end

    // word layout: {used, key}
    assign mem_we    = cmd.clr_step || (cmd.probe_cmp && slot_empty && mode_reg);
    assign mem_waddr = cmd.clr_step ? clr_reg : pos_reg;
    assign mem_wdata = cmd.clr_step ? '0 : {1'b1, key_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.probe_rd) begin
            rd_q <= mem[pos_w];
        end
    end

    assign sts.clr_last   = (clr_reg == SLOT_W'(MAX_SLOTS - 1));
    assign sts.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.found      = slot_empty || slot_hit;
    assign sts.last_probe = (n_reg == size_m1);

    assign out_slot   = m_slot_reg;
    assign out_status = m_status_reg;

    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> EFF_W'(rem_reg) < size_eff)
        else $error("partial remainder not below table size");

    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.probe_rd |-> EFF_W'(pos_w) < size_eff)
        else $error("probe slot outside table");

endmodule

[rtl/core/hash_table_quadratic_probe_top.sv]
// Open-addressing hash table of 31-bit keys with quadratic probing
// (home = key mod table_size, then +1, -1, +4, -4, ...). One word is
// handled at a time, through the 4-bit-per-cycle remainder unit and one
// registered read of the slot memory per probe; a finished result waits in
// the output register. After reset the slot memory is cleared one slot a
// cycle, during which s_tready stays low (cfg writes are taken).
// table_size should be a prime; write it only while idle.
module hash_table_quadratic_probe_top
    import hqp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,   // table_size

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [30:0] key
    input  logic                 s_tuser,    // [0] mode: 0 find, 1 find and insert

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // [9:0] slot
    output logic [STAT_W-1:0]    m_tuser     // [1:0] status
);

    hqp_cmd_t          cmd;
    hqp_sts_t          sts;
    logic [SLOT_W-1:0] out_slot;
    status_t           out_status;

    assign cfg_ready = 1'b1;

    hqp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .sts     (sts),
        .cmd     (cmd)
    );

    hqp_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .in_mode    (s_tuser),
        .in_key     (s_tdata[KEY_W-1:0]),
        .cmd        (cmd),
        .sts        (sts),
        .out_slot   (out_slot),
        .out_status (out_status)
    );

    assign m_tdata = M_TDATA_W'(out_slot);
    assign m_tuser = out_status;

endmodule
